// ===== hw/rtl/keyframe_spline_player_unit_macros.svh =====
// Assertion macros of the keyframe spline player checker.
`ifndef KEYFRAME_SPLINE_PLAYER_UNIT_MACROS_SVH
`define KEYFRAME_SPLINE_PLAYER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define KSP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("keyframe spline player check failed");

// Clocked assertion that also holds across reset.
`define KSP_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keyframe spline player reset check failed");

`endif

// ===== hw/rtl/ksp_pkg.sv =====
// Shared types and constants of the keyframe spline player.
`default_nettype none
package ksp_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_RSVD  = 2'd3
  } ksp_cmd_t;

  // Divider geometry: a 32-bit value shifted up by 16 fraction bits.
  localparam int DVD_W = 48;
  localparam int DVS_W = 32;

  // Spline coefficient and shared multiplier widths.
  localparam int CF_W   = 37;
  localparam int UM_W   = 18;
  localparam int PROD_W = CF_W + UM_W;
  localparam int ACC_W  = 64;

  typedef struct packed {
    logic        [31:0] ktime;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
  } ksp_key_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ksp_in_if.sv =====
// Input command channel of the keyframe spline player.
`default_nettype none
interface ksp_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [31:0] key_time;
  logic        [31:0] dt;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic signed [31:0] in_tgt_x;
  logic signed [31:0] in_tgt_y;
  logic signed [31:0] in_tgt_z;

  modport source (output valid, cmd, key_time, dt, in_pos_x, in_pos_y, in_pos_z,
                  in_tgt_x, in_tgt_y, in_tgt_z, input ready);
  modport sink (input valid, cmd, key_time, dt, in_pos_x, in_pos_y, in_pos_z,
                in_tgt_x, in_tgt_y, in_tgt_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ksp_out_if.sv =====
// Result channel of the keyframe spline player.
`default_nettype none
interface ksp_out_if;
  logic               valid;
  logic               ready;
  logic               status;
  logic               out_valid;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_tgt_x;
  logic signed [31:0] out_tgt_y;
  logic signed [31:0] out_tgt_z;

  modport source (output valid, status, out_valid, out_pos_x, out_pos_y, out_pos_z,
                  out_tgt_x, out_tgt_y, out_tgt_z, input ready);
  modport sink (input valid, status, out_valid, out_pos_x, out_pos_y, out_pos_z,
                out_tgt_x, out_tgt_y, out_tgt_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ksp_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the modulo and u.
`default_nettype none
module ksp_div import ksp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quot,
  output logic [DVS_W-1:0] rem
);
  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DVD_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // The partial remainder stays below the divisor, so it fits the divisor width.
        rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// ===== hw/rtl/keyframe_spline_player_unit.sv =====
// Top level of the keyframe spline player: key table, sequencer and spline datapath.
//
//   channel   direction  carries
//   in_if     sink       cmd, key_time, dt, key position and target
//   out_if    source     status, out_valid, position and target
//   cfg_*     write      loop_enable bit
//
// One command is in flight at a time; in_if.ready is high only when the sequencer
// is idle and the result register is empty. Clear and unused codes are answered from idle.
// Add moves later keys up one slot at a time through the key table.
// A tick on two or more keys runs the divider for the loop modulo (skipped when
// looping is off or the span is empty), steps through the segments, loads four
// keys, runs the divider for u, forms u^2 and u^3, then three products per component.
// Reset is synchronous and clears control state only; the key table is not cleared.
// A stalled result holds in the output register until its transfer completes.
`default_nettype none
module keyframe_spline_player_unit import ksp_pkg::*; #(
  parameter int MAX_KEYS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  ksp_in_if.sink    in_if,
  ksp_out_if.source out_if
);
  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int IW = CW + 1;

  typedef enum logic [20:0] {
    S_IDLE    = 21'd1,
    S_ADD_RD  = 21'd2,
    S_ADD_CMP = 21'd4,
    S_ONE     = 21'd8,
    S_RDE     = 21'd16,
    S_SPAN    = 21'd32,
    S_MOD     = 21'd64,
    S_CLAMP   = 21'd128,
    S_SEG_RD  = 21'd256,
    S_SEG_CMP = 21'd512,
    S_LD      = 21'd1024,
    S_LDW     = 21'd2048,
    S_DIVU    = 21'd4096,
    S_DIVW    = 21'd8192,
    S_U2      = 21'd16384,
    S_U3      = 21'd32768,
    S_U3W     = 21'd65536,
    S_C1      = 21'd131072,
    S_C2      = 21'd262144,
    S_C3      = 21'd524288,
    S_C4      = 21'd1048576
  } state_t;

  typedef struct packed {
    logic        [1:0]  cmd;
    logic        [31:0] key_time;
    logic        [31:0] dt;
    ksp_key_t           key;
  } item_t;

  typedef struct packed {
    logic               status;
    logic               res_valid;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic signed [31:0] tgt_z;
  } res_t;

  function automatic logic signed [CF_W-1:0] comp_sel(input ksp_key_t k,
                                                      input logic [2:0] c);
    logic signed [31:0] v;
    case (c)
      3'd0:    v = k.pos_x;
      3'd1:    v = k.pos_y;
      3'd2:    v = k.pos_z;
      3'd3:    v = k.tgt_x;
      3'd4:    v = k.tgt_y;
      default: v = k.tgt_z;
    endcase
    return CF_W'(v);
  endfunction

  state_t              state_r, state_nxt;
  item_t               item_r;
  res_t                out_r;
  logic                ovalid_r;
  logic                loop_r;
  logic [CW-1:0]       cnt_r;
  logic [31:0]         elapsed_r;
  logic [AW-1:0]       j_r;
  logic [AW-1:0]       i_r;
  logic [1:0]          ld_r;
  logic [2:0]          comp_r;
  logic [31:0]         start_r;
  logic [31:0]         end_r;
  logic [32:0]         t_r;
  logic [16:0]         u_r, u2_r, u3_r;
  ksp_key_t            rows_r [4];
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  ksp_key_t            mem [MAX_KEYS];
  ksp_key_t            rdata_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  ksp_key_t            mem_wdata;

  logic                div_start, div_done;
  logic [DVD_W-1:0]    div_dvd, div_quot;
  logic [DVS_W-1:0]    div_dvs, div_rem;

  logic signed [CF_W-1:0] mul_a;
  logic signed [UM_W-1:0] mul_b;
  logic signed [CF_W-1:0] p0, p1, p2, p3, c1, c2, c3;
  logic signed [ACC_W-1:0] prod_ext, acc_init, acc_fin, q;
  logic signed [31:0]     q_sat;

  logic                in_acc;
  logic                full;
  logic                seg_more;
  logic [AW-1:0]       i0, i3, ld_addr;
  logic [32:0]         el_sum;
  logic [31:0]         t1, t2;

  assign in_acc   = in_if.valid && in_if.ready;
  assign full     = cnt_r == CW'(MAX_KEYS);
  assign seg_more = (IW'(i_r) + IW'(2)) < IW'(cnt_r);
  assign i0       = (i_r == '0) ? i_r : i_r - AW'(1);
  assign i3       = seg_more ? i_r + AW'(2) : i_r + AW'(1);
  assign el_sum   = {1'b0, elapsed_r} + {1'b0, in_if.dt};
  assign t1       = rows_r[1].ktime;
  assign t2       = rows_r[2].ktime;

  always_comb begin
    case (ld_r)
      2'd0:    ld_addr = i0;
      2'd1:    ld_addr = i_r;
      2'd2:    ld_addr = i_r + AW'(1);
      default: ld_addr = i3;
    endcase
  end

  // Catmull-Rom coefficients of the component in work.
  always_comb begin
    p0 = comp_sel(rows_r[0], comp_r);
    p1 = comp_sel(rows_r[1], comp_r);
    p2 = comp_sel(rows_r[2], comp_r);
    p3 = comp_sel(rows_r[3], comp_r);
    c1 = p2 - p0;
    c2 = (p0 <<< 1) - CF_W'(5) * p1 + (p2 <<< 2) - p3;
    c3 = CF_W'(3) * (p1 - p2) + p3 - p0;
  end

  assign prod_ext = ACC_W'(prod_r);
  assign acc_init = (ACC_W'(p1) <<< 17) + ACC_W'(65536);
  assign acc_fin  = acc_r + prod_ext;
  assign q        = acc_fin >>> 17;

  always_comb begin
    if (q > ACC_W'(64'sd2147483647)) begin
      q_sat = 32'sh7fffffff;
    end else if (q < -ACC_W'(64'sd2147483648)) begin
      q_sat = 32'sh80000000;
    end else begin
      q_sat = q[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = j_r;
    mem_wdata = item_r.key;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_if.cmd)
            CMD_ADD: begin
              if (!full) state_nxt = S_ADD_RD;
            end
            CMD_TICK: begin
              if (cnt_r == CW'(1)) state_nxt = S_ONE;
              else if (cnt_r > CW'(1)) state_nxt = S_RDE;
            end
            default: ;
          endcase
        end
      end
      S_ADD_RD: begin
        if (j_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_raddr = j_r - AW'(1);
          state_nxt = S_ADD_CMP;
        end
      end
      S_ADD_CMP: begin
        // Later keys move up one slot; equal times stay ahead of the new key.
        mem_we = 1'b1;
        if (rdata_r.ktime > item_r.key_time) begin
          mem_wdata = rdata_r;
          state_nxt = S_ADD_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ONE: state_nxt = S_IDLE;
      S_RDE: begin
        mem_raddr = AW'(cnt_r - CW'(1));
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        if (loop_r && rdata_r.ktime > start_r) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(elapsed_r);
          div_dvs   = rdata_r.ktime - start_r;
          state_nxt = S_MOD;
        end else begin
          state_nxt = S_CLAMP;
        end
      end
      S_MOD: begin
        if (div_done) state_nxt = S_CLAMP;
      end
      S_CLAMP: state_nxt = S_SEG_RD;
      S_SEG_RD: begin
        if (seg_more) begin
          mem_raddr = i_r + AW'(1);
          state_nxt = S_SEG_CMP;
        end else begin
          state_nxt = S_LD;
        end
      end
      S_SEG_CMP: begin
        if ({1'b0, rdata_r.ktime} < t_r) state_nxt = S_SEG_RD;
        else state_nxt = S_LD;
      end
      S_LD: begin
        mem_raddr = ld_addr;
        state_nxt = S_LDW;
      end
      S_LDW: state_nxt = (ld_r == 2'd3) ? S_DIVU : S_LD;
      S_DIVU: begin
        div_start = 1'b1;
        div_dvd   = {t_r[31:0] - t1, 16'h0000};
        div_dvs   = (t2 > t1) ? t2 - t1 : 32'd1;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_done) state_nxt = S_U2;
      end
      S_U2: begin
        mul_a     = CF_W'(u_r);
        mul_b     = UM_W'(u_r);
        state_nxt = S_U3;
      end
      S_U3: begin
        mul_a     = CF_W'(u_r);
        mul_b     = UM_W'(prod_r[32:16]);
        state_nxt = S_U3W;
      end
      S_U3W: state_nxt = S_C1;
      S_C1: begin
        mul_a     = c1;
        mul_b     = UM_W'(u_r);
        state_nxt = S_C2;
      end
      S_C2: begin
        mul_a     = c2;
        mul_b     = UM_W'(u2_r);
        state_nxt = S_C3;
      end
      S_C3: begin
        mul_a     = c3;
        mul_b     = UM_W'(u3_r);
        state_nxt = S_C4;
      end
      S_C4: state_nxt = (comp_r == 3'd5) ? S_IDLE : S_C1;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_r <= mem[mem_raddr];
  end

  ksp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      loop_r    <= 1'b0;
      cnt_r     <= '0;
      elapsed_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) loop_r <= cfg_wdata;
      if (out_if.valid && out_if.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            item_r <= {in_if.cmd, in_if.key_time, in_if.dt, in_if.key_time,
                       in_if.in_pos_x, in_if.in_pos_y, in_if.in_pos_z,
                       in_if.in_tgt_x, in_if.in_tgt_y, in_if.in_tgt_z};
            // An add to a full table is refused with status set.
            out_r  <= {(in_if.cmd == CMD_ADD) && full, 1'b0, 192'd0};
            case (in_if.cmd)
              CMD_CLEAR: begin
                cnt_r     <= '0;
                elapsed_r <= '0;
                ovalid_r  <= 1'b1;
              end
              CMD_ADD: begin
                if (full) begin
                  ovalid_r <= 1'b1;
                end else begin
                  j_r <= AW'(cnt_r);
                end
              end
              CMD_TICK: begin
                if (cnt_r == '0) begin
                  ovalid_r <= 1'b1;
                end else if (cnt_r > CW'(1)) begin
                  elapsed_r <= el_sum[32] ? 32'hffffffff : el_sum[31:0];
                end
              end
              default: ovalid_r <= 1'b1;
            endcase
          end
        end
        S_ADD_RD: begin
          if (j_r == '0) begin
            cnt_r    <= cnt_r + CW'(1);
            ovalid_r <= 1'b1;
          end
        end
        S_ADD_CMP: begin
          if (rdata_r.ktime > item_r.key_time) begin
            j_r <= j_r - AW'(1);
          end else begin
            cnt_r    <= cnt_r + CW'(1);
            ovalid_r <= 1'b1;
          end
        end
        S_ONE: begin
          out_r.res_valid <= 1'b1;
          out_r.pos_x     <= rdata_r.pos_x;
          out_r.pos_y     <= rdata_r.pos_y;
          out_r.pos_z     <= rdata_r.pos_z;
          out_r.tgt_x     <= rdata_r.tgt_x;
          out_r.tgt_y     <= rdata_r.tgt_y;
          out_r.tgt_z     <= rdata_r.tgt_z;
          ovalid_r        <= 1'b1;
        end
        S_RDE: start_r <= rdata_r.ktime;
        S_SPAN: begin
          end_r <= rdata_r.ktime;
          t_r   <= {1'b0, start_r} + {1'b0, elapsed_r};
        end
        S_MOD: begin
          if (div_done) t_r <= {1'b0, start_r} + {1'b0, div_rem};
        end
        S_CLAMP: begin
          if (t_r > {1'b0, end_r}) t_r <= {1'b0, end_r};
          i_r  <= '0;
          ld_r <= '0;
        end
        S_SEG_CMP: begin
          if ({1'b0, rdata_r.ktime} < t_r) i_r <= i_r + AW'(1);
        end
        S_LDW: begin
          rows_r[ld_r] <= rdata_r;
          ld_r         <= ld_r + 2'd1;
        end
        S_DIVW: begin
          if (div_done) u_r <= div_quot[16:0];
        end
        S_U3: u2_r <= prod_r[32:16];
        S_U3W: begin
          u3_r   <= prod_r[32:16];
          comp_r <= '0;
        end
        S_C1: acc_r <= acc_init;
        S_C2: acc_r <= acc_fin;
        S_C3: acc_r <= acc_fin;
        S_C4: begin
          case (comp_r)
            3'd0:    out_r.pos_x <= q_sat;
            3'd1:    out_r.pos_y <= q_sat;
            3'd2:    out_r.pos_z <= q_sat;
            3'd3:    out_r.tgt_x <= q_sat;
            3'd4:    out_r.tgt_y <= q_sat;
            default: out_r.tgt_z <= q_sat;
          endcase
          comp_r <= comp_r + 3'd1;
          if (comp_r == 3'd5) begin
            out_r.res_valid <= 1'b1;
            ovalid_r        <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_if.ready      = (state_r == S_IDLE) && !ovalid_r;
  assign out_if.valid     = ovalid_r;
  assign out_if.status    = out_r.status;
  assign out_if.out_valid = out_r.res_valid;
  assign out_if.out_pos_x = out_r.pos_x;
  assign out_if.out_pos_y = out_r.pos_y;
  assign out_if.out_pos_z = out_r.pos_z;
  assign out_if.out_tgt_x = out_r.tgt_x;
  assign out_if.out_tgt_y = out_r.tgt_y;
  assign out_if.out_tgt_z = out_r.tgt_z;
endmodule
`default_nettype wire

// ===== hw/rtl/ksp_checker.sv =====
// Port-level checks of the keyframe spline player and their bind to the top level.
`default_nettype none
`include "keyframe_spline_player_unit_macros.svh"
module ksp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               res_valid,
  input logic signed [31:0] res_pos_x,
  input logic signed [31:0] res_pos_y,
  input logic signed [31:0] res_pos_z,
  input logic signed [31:0] res_tgt_x,
  input logic signed [31:0] res_tgt_y,
  input logic signed [31:0] res_tgt_z
);
  // A waiting result must not be dropped.
  `KSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  // One command at a time: after an input transfer the block is busy.
  `KSP_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready)
  // No new command is taken while a result waits.
  `KSP_ASSERT(a_no_take_pending, out_valid |-> !in_ready)
  // Results without a playback sample carry all-zero coordinates.
  `KSP_ASSERT(a_zero_fields, out_valid && !res_valid |-> res_pos_x == 0 && res_pos_y == 0 && res_pos_z == 0 && res_tgt_x == 0 && res_tgt_y == 0 && res_tgt_z == 0)
  `KSP_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid)
endmodule

bind keyframe_spline_player_unit ksp_checker u_ksp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .res_valid (out_if.out_valid),
  .res_pos_x (out_if.out_pos_x),
  .res_pos_y (out_if.out_pos_y),
  .res_pos_z (out_if.out_pos_z),
  .res_tgt_x (out_if.out_tgt_x),
  .res_tgt_y (out_if.out_tgt_y),
  .res_tgt_z (out_if.out_tgt_z)
);
`default_nettype wire

// ===== test/keyframe_spline_player_unit_tb.sv =====
// Testbench of the keyframe spline player: directed and random commands checked against a predictor.
`default_nettype none
module keyframe_spline_player_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ksp_pkg::*;

  localparam int NKEYS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic               status;
    logic               valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  ksp_in_if  in_ch();
  ksp_out_if out_ch();

  keyframe_spline_player_unit #(.MAX_KEYS(NKEYS)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state.
  ksp_key_t    track[NKEYS];
  int          track_len;
  logic [31:0] play_time;
  logic        wrap_on;

  pose_t pose_queue[$];
  int    errors;
  int    idle_cycles;

  function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                                logic signed [31:0] c, logic signed [31:0] d,
                                                longint u, longint u2, longint u3);
    longint p0, p1, p2, p3, s, q;
    p0 = a; p1 = b; p2 = c; p3 = d;
    s = 2 * p1 * 65536 + (p2 - p0) * u + (2 * p0 - 5 * p1 + 4 * p2 - p3) * u2
      + (-p0 + 3 * p1 - 3 * p2 + p3) * u3 + 65536;
    q = s >>> 17;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic pose_t predict_pose(ksp_cmd_t cmd, ksp_key_t k, logic [31:0] dt);
    pose_t r;
    int p, i, i0, i3;
    logic [63:0] e, t0, t1, t, ta, tb, den;
    longint u, u2, u3;
    ksp_key_t a, b, c, d;
    r = '0;
    if (cmd == CMD_CLEAR) begin
      track_len = 0;
      play_time = '0;
    end else if (cmd == CMD_ADD) begin
      if (track_len >= NKEYS) begin
        r.status = 1'b1;
        return r;
      end
      p = 0;
      while (p < track_len && track[p].ktime <= k.ktime) p++;
      for (int j = track_len; j > p; j--) track[j] = track[j-1];
      track[p] = k;
      track_len++;
    end else if (cmd == CMD_TICK) begin
      if (track_len == 0) return r;
      r.valid = 1'b1;
      if (track_len == 1) begin
        r.px = track[0].pos_x; r.py = track[0].pos_y; r.pz = track[0].pos_z;
        r.tx = track[0].tgt_x; r.ty = track[0].tgt_y; r.tz = track[0].tgt_z;
        return r;
      end
      e = 64'(play_time) + 64'(dt);
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      play_time = e[31:0];
      t0 = track[0].ktime;
      t1 = track[track_len-1].ktime;
      t = t0 + e;
      if (wrap_on && t1 > t0) t = t0 + e % (t1 - t0);
      if (t > t1) t = t1;
      i = 0;
      while (i + 2 < track_len && 64'(track[i+1].ktime) < t) i++;
      ta = track[i].ktime;
      tb = track[i+1].ktime;
      den = (tb > ta) ? tb - ta : 64'd1;
      u = longint'(((t - ta) << 16) / den);
      u2 = (u * u) >>> 16;
      u3 = (u2 * u) >>> 16;
      i0 = (i > 0) ? i - 1 : i;
      i3 = (i + 2 < track_len) ? i + 2 : i + 1;
      a = track[i0]; b = track[i]; c = track[i+1]; d = track[i3];
      r.px = blend(a.pos_x, b.pos_x, c.pos_x, d.pos_x, u, u2, u3);
      r.py = blend(a.pos_y, b.pos_y, c.pos_y, d.pos_y, u, u2, u3);
      r.pz = blend(a.pos_z, b.pos_z, c.pos_z, d.pos_z, u, u2, u3);
      r.tx = blend(a.tgt_x, b.tgt_x, c.tgt_x, d.tgt_x, u, u2, u3);
      r.ty = blend(a.tgt_y, b.tgt_y, c.tgt_y, d.tgt_y, u, u2, u3);
      r.tz = blend(a.tgt_z, b.tgt_z, c.tgt_z, d.tgt_z, u, u2, u3);
    end
    return r;
  endfunction

  task automatic send_command(logic [1:0] cmd, ksp_key_t k, logic [31:0] dt);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= cmd;
    in_ch.key_time <= k.ktime;
    in_ch.dt       <= dt;
    in_ch.in_pos_x <= k.pos_x;
    in_ch.in_pos_y <= k.pos_y;
    in_ch.in_pos_z <= k.pos_z;
    in_ch.in_tgt_x <= k.tgt_x;
    in_ch.in_tgt_y <= k.tgt_y;
    in_ch.in_tgt_z <= k.tgt_z;
    do @(posedge clk); while (!in_ch.ready);
    pose_queue.push_back(predict_pose(ksp_cmd_t'(cmd), k, dt));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 400000)) - 200000);
      default: return $urandom;
    endcase
  endfunction

  function automatic ksp_key_t rand_key(logic [31:0] tm);
    ksp_key_t k;
    k.ktime = tm;
    k.pos_x = rand_coord(); k.pos_y = rand_coord(); k.pos_z = rand_coord();
    k.tgt_x = rand_coord(); k.tgt_y = rand_coord(); k.tgt_z = rand_coord();
    return k;
  endfunction

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_loop(logic v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    wrap_on = v;
  endtask

  task automatic test_directed();
    send_command(CMD_TICK, rand_key(0), 32'h0001_0000);
    send_command(CMD_ADD, rand_key(32'h0002_0000), 0);
    send_command(CMD_TICK, rand_key(0), 32'hFFFF_FFFF);
    send_command(CMD_ADD, rand_key(32'h0002_0000), 0);
    send_command(CMD_TICK, rand_key(0), 32'h0000_8000);
    send_command(CMD_ADD, rand_key(32'h0000_0000), 0);
    send_command(CMD_ADD, rand_key(32'hFFFF_FFFF), 0);
    send_command(CMD_TICK, rand_key(0), 32'h0001_0000);
    send_command(CMD_TICK, rand_key(0), 32'hFFFF_FFFF);
    send_command(CMD_TICK, rand_key(0), 32'hFFFF_FFFF);
    send_command(CMD_RSVD, rand_key(32'h1234_5678), 32'h5555_AAAA);
    send_command(CMD_CLEAR, rand_key(0), 0);
    for (int j = 0; j < NKEYS + 1; j++)
      send_command(CMD_ADD, rand_key(32'(j) << 14), 0);
    send_command(CMD_TICK, rand_key(0), 32'h0000_3000);
  endtask

  task automatic test_random_tracks(int n);
    int sent, keys;
    logic [31:0] base;
    sent = 0;
    while (sent < n) begin
      send_command(CMD_CLEAR, rand_key(0), 0);
      keys = $urandom_range(1, NKEYS + 2);
      base = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
      for (int j = 0; j < keys; j++) begin
        if ($urandom_range(0, 3) == 0)
          send_command(CMD_ADD, rand_key($urandom), 0);
        else
          send_command(CMD_ADD, rand_key(base + $urandom_range(0, 32'h0008_0000)), 0);
      end
      sent += keys + 1;
      for (int j = $urandom_range(3, 12); j > 0; j--) begin
        case ($urandom_range(0, 9))
          0: send_command(CMD_TICK, rand_key(0), $urandom);
          1: send_command(CMD_RSVD, rand_key($urandom), $urandom);
          2: send_command(CMD_ADD, rand_key($urandom), $urandom);
          default: send_command(CMD_TICK, rand_key($urandom), $urandom_range(0, 32'h0002_0000));
        endcase
        sent++;
      end
    end
  endtask

  // Result side: random backpressure and checking against the oldest prediction.
  initial begin
    int rgap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      rgap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (rgap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (rgap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      begin
        pose_t got, want;
        got = {out_ch.status, out_ch.out_valid, out_ch.out_pos_x, out_ch.out_pos_y,
               out_ch.out_pos_z, out_ch.out_tgt_x, out_ch.out_tgt_y, out_ch.out_tgt_z};
        if (pose_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("ERROR: unexpected result %h", got);
        end else begin
          want = pose_queue.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("ERROR: mismatch expected st=%b v=%b pos=%h %h %h tgt=%h %h %h, got st=%b v=%b pos=%h %h %h tgt=%h %h %h",
                       want.status, want.valid, want.px, want.py, want.pz,
                       want.tx, want.ty, want.tz, got.status, got.valid, got.px,
                       got.py, got.pz, got.tx, got.ty, got.tz);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    track_len = 0;
    play_time = '0;
    wrap_on = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_CLEAR;
    in_ch.key_time = '0;
    in_ch.dt = '0;
    in_ch.in_pos_x = '0; in_ch.in_pos_y = '0; in_ch.in_pos_z = '0;
    in_ch.in_tgt_x = '0; in_ch.in_tgt_y = '0; in_ch.in_tgt_z = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_loop(1'b1);
    test_directed();
    test_random_tracks(450);
    write_loop(1'b0);
    test_random_tracks(450);
    write_loop(1'b1);
    test_random_tracks(400);
    wait_drained();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

// ===== keyframe_spline_player_unit.f =====
+incdir+hw/rtl
hw/rtl/ksp_pkg.sv
hw/rtl/ksp_in_if.sv
hw/rtl/ksp_out_if.sv
hw/rtl/ksp_div.sv
hw/rtl/keyframe_spline_player_unit.sv
hw/rtl/ksp_checker.sv
test/keyframe_spline_player_unit_tb.sv
